// ===== rtl/lowest_free_id_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// lowest_free_id_allocator_macros
// Assertion macros used by the allocator's checker file, lfia_checker.sv.
// ----------------------------------------------------------------------------
`ifndef LOWEST_FREE_ID_ALLOCATOR_MACROS_SVH
`define LOWEST_FREE_ID_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define LFIA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LFIA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lfia_pkg.sv =====
// ----------------------------------------------------------------------------
// lfia_pkg
// Types, constants and helpers shared by the allocator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lfia_pkg;

  localparam int ID_W   = 32;
  localparam int WORD_W = 32;
  localparam int OFF_W  = 5;
  localparam int CFG_W  = 11;

  typedef logic [ID_W-1:0]   id_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [CFG_W-1:0]  cfg_t;

  localparam id_t  ALL_ONES  = 32'hFFFF_FFFF;
  localparam cfg_t CFG_RESET = 11'd1024;

  localparam logic CMD_REGISTER = 1'b0;
  localparam logic CMD_GENERATE = 1'b1;

  typedef struct packed {
    logic clear_en;
    logic load;
    logic run;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic step_done;
  } dp_status_t;

  // one-hot word to bit index; each index bit is an OR over the word
  function automatic logic [OFF_W-1:0] onehot_to_idx(input word_t v);
    logic [OFF_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (v[i]) begin
        idx = idx | OFF_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== rtl/lfia_ram.sv =====
// ----------------------------------------------------------------------------
// lfia_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfia_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                         wdata,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/lfia_ctrl.sv =====
// ----------------------------------------------------------------------------
// lfia_ctrl
// Controller: clear pass after reset, item load, run until the step is done.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfia_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  lfia_pkg::dp_status_t status,
  output lfia_pkg::ctrl_cmd_t  cmd,
  output logic                busy
);
  import lfia_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_RUN   = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        cmd.run = 1'b1;
        if (status.step_done) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== rtl/lfia_dp.sv =====
// ----------------------------------------------------------------------------
// lfia_dp
// Datapath: bitmap RAM, next-free pointer, row scanner and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfia_dp #(
  parameter int MAP_CAPACITY = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lfia_pkg::ctrl_cmd_t  cmd,
  output lfia_pkg::dp_status_t status,
  input  logic                 command,
  input  lfia_pkg::id_t        instance_id,
  input  logic                 map_size_we,
  input  lfia_pkg::cfg_t       map_size,
  output lfia_pkg::id_t        issued_id,
  output lfia_pkg::id_t        next_free,
  output logic                 overflow,
  output logic                 done
);
  import lfia_pkg::*;

  localparam int ROWS  = (MAP_CAPACITY + WORD_W - 1) / WORD_W;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SZ_W  = $clog2(MAP_CAPACITY + 1);

  // registers
  cfg_t             cfg_size;
  logic [ROW_W-1:0] clr_row;
  id_t              next_id;
  logic             cmd_q;
  id_t              id_q;
  id_t              ptr;

  // datapath signals
  logic [SZ_W-1:0]  eff_size;
  id_t              size32;
  id_t              ptr_first;
  logic             is_gen;
  id_t              row_base;
  id_t              row_end;
  word_t            beyond;
  word_t            lower;
  word_t            cand;
  word_t            lowest;
  logic [OFF_W-1:0] hit_idx;
  logic             hit;
  logic             ptr_adv;
  id_t              new_next;
  logic             ram_we;
  logic [ROW_W-1:0] ram_addr;
  word_t            ram_wdata;
  word_t            ram_rdata;

  // sizes above the capacity act as the capacity
  always_comb begin
    if (32'(cfg_size) > 32'(MAP_CAPACITY)) begin
      eff_size = SZ_W'(MAP_CAPACITY);
    end else begin
      eff_size = SZ_W'(cfg_size);
    end
  end
  assign size32 = 32'(eff_size);

  assign ptr_first = next_id + 32'd1;
  assign is_gen    = (cmd_q == CMD_GENERATE);
  assign row_base  = {ptr[ID_W-1:OFF_W], OFF_W'(0)};
  assign row_end   = row_base + 32'(WORD_W);

  // ids at or past the size count as free; only offsets at or above ptr count
  always_comb begin
    if (size32 > row_base + 32'(WORD_W - 1)) begin
      beyond = '0;
    end else begin
      beyond = ~((word_t'(1) << size32[OFF_W-1:0]) - word_t'(1));
    end
  end
  assign lower   = ~((word_t'(1) << ptr[OFF_W-1:0]) - word_t'(1));
  assign cand    = (~ram_rdata | beyond) & lower;
  assign hit     = |cand;
  assign lowest  = cand & (~cand + word_t'(1));
  assign hit_idx = onehot_to_idx(lowest);

  always_comb begin
    status.clear_last = (clr_row == ROW_W'(ROWS - 1));
    new_next          = next_id;
    status.step_done  = 1'b1;
    ptr_adv           = 1'b0;
    if (!is_gen) begin
      if (next_id == id_q && next_id != ALL_ONES) begin
        new_next = next_id + 32'd1;
      end
    end else if (next_id == ALL_ONES) begin
      new_next = next_id;
    end else if (ptr >= size32) begin
      new_next = ptr;
    end else if (hit) begin
      new_next = row_base | 32'(hit_idx);
    end else if (row_end >= size32) begin
      new_next = row_end;
    end else begin
      status.step_done = 1'b0;
      ptr_adv          = 1'b1;
    end
  end

  // RAM port: clear sweep, first read on load, read-modify-write or next row
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = ram_rdata | (word_t'(1) << id_q[OFF_W-1:0]);
    ram_addr  = row_end[ROW_W+OFF_W-1:OFF_W];
    if (cmd.clear_en) begin
      ram_we    = 1'b1;
      ram_wdata = '0;
      ram_addr  = clr_row;
    end else if (cmd.load) begin
      if (command == CMD_GENERATE) begin
        ram_addr = ptr_first[ROW_W+OFF_W-1:OFF_W];
      end else begin
        ram_addr = instance_id[ROW_W+OFF_W-1:OFF_W];
      end
    end else if (cmd.run && !is_gen) begin
      ram_addr = id_q[ROW_W+OFF_W-1:OFF_W];
      ram_we   = (id_q < size32);
    end
  end

  lfia_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROWS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_size <= CFG_RESET;
      clr_row  <= '0;
      next_id  <= 32'd1;
      overflow <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (map_size_we) begin
        cfg_size <= map_size;
      end
      if (cmd.clear_en) begin
        clr_row <= clr_row + ROW_W'(1);
      end
      if (cmd.finish) begin
        next_id  <= new_next;
        overflow <= overflow | (new_next == ALL_ONES);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q <= command;
      id_q  <= instance_id;
      ptr   <= ptr_first;
    end else if (cmd.run && ptr_adv) begin
      ptr <= row_end;
    end
    if (cmd.finish) begin
      issued_id <= is_gen ? next_id : '0;
    end
  end

  assign next_free = next_id;

endmodule

// ===== rtl/lowest_free_id_allocator.sv =====
// ----------------------------------------------------------------------------
// lowest_free_id_allocator
// Used-bitmap id allocator with a next-free pointer and sticky overflow.
// ----------------------------------------------------------------------------
// Channel  | Handshake           | Words
// input    | start / busy        | command, instance_id
// result   | done (one cycle)    | issued_id, next_free, overflow
// config   | map_size_we         | map_size
//
// A command is accepted only while busy is low. A generate command scans
// further 32-id bitmap rows until it finds a free id;
// the scan reads one row per cycle from the single-port bitmap RAM.
// After reset a clearing pass zeroes all ceil(MAP_CAPACITY / 32) bitmap rows
// (32 at the default), one row per cycle, with busy high throughout.
// Results cannot be stalled; done marks each word for exactly one cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lowest_free_id_allocator #(
  parameter int MAP_CAPACITY = 1024
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  logic           command,
  input  lfia_pkg::id_t  instance_id,
  input  logic           map_size_we,
  input  lfia_pkg::cfg_t map_size,
  output logic           done,
  output lfia_pkg::id_t  issued_id,
  output lfia_pkg::id_t  next_free,
  output logic           overflow
);
  import lfia_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  lfia_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  lfia_dp #(
    .MAP_CAPACITY (MAP_CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .command     (command),
    .instance_id (instance_id),
    .map_size_we (map_size_we),
    .map_size    (map_size),
    .issued_id   (issued_id),
    .next_free   (next_free),
    .overflow    (overflow),
    .done        (done)
  );

endmodule

// ===== rtl/lfia_checker.sv =====
// ----------------------------------------------------------------------------
// lfia_checker
// Port-level checks on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lowest_free_id_allocator_macros.svh"

module lfia_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input lfia_pkg::id_t next_free,
  input logic          overflow
);
  import lfia_pkg::*;

  `LFIA_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy, "no busy after accept")
  `LFIA_ASSERT_NXT(a_done_single, clk, rst, done, !done, "result strobe longer than one cycle")
  `LFIA_ASSERT_IMP(a_done_idle, clk, rst, done, !busy, "result strobe while busy")
  `LFIA_ASSERT_IMP(a_ovf_set, clk, rst, done && next_free == ALL_ONES, overflow, "overflow missing")
  `LFIA_ASSERT_NXT(a_ovf_sticky, clk, rst, overflow, overflow, "overflow dropped")

endmodule

bind lowest_free_id_allocator lfia_checker u_lfia_checker (.*);

// ===== tb/lowest_free_id_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// lowest_free_id_allocator_tb
// Self-checking bench for the lowest-free id allocator: a queue-fed driver
// issues register/generate words, an in-bench bitmap model predicts each
// result word, and a monitor compares every done strobe against it across
// several map_size settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lowest_free_id_allocator_tb;
  import lfia_pkg::*;

  localparam int          MAP_CAP   = 1024;
  localparam int          IDLE_TOUT = 4000;

  typedef struct {
    logic cmd;
    id_t  id;
  } cmd_word_t;

  typedef struct {
    id_t  issued;
    id_t  next_free;
    logic ovf;
  } alloc_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic command = CMD_REGISTER;
  id_t  instance_id = '0;
  logic map_size_we = 1'b0;
  cfg_t map_size = CFG_RESET;
  logic busy, done, overflow;
  id_t  issued_id, next_free;

  lowest_free_id_allocator #(.MAP_CAPACITY(MAP_CAP)) dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .command     (command),
    .instance_id (instance_id),
    .map_size_we (map_size_we),
    .map_size    (map_size),
    .done        (done),
    .issued_id   (issued_id),
    .next_free   (next_free),
    .overflow    (overflow)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // allocator model state
  bit   used_bits [MAP_CAP];
  id_t  ptr_next = 32'd1;
  logic ovf_seen = 1'b0;
  cfg_t cfg_size = CFG_RESET;

  cmd_word_t   cmd_queue[$];
  alloc_word_t expected_allocs[$];
  cmd_word_t   drv_word;
  alloc_word_t want;
  int          mismatches = 0;
  int          gap_left = 0;
  bit          idle_en = 1'b0;
  int          quiet_cycles = 0;

  function automatic int unsigned eff_size();
    return (cfg_size > MAP_CAP) ? MAP_CAP : cfg_size;
  endfunction

  function automatic alloc_word_t predict_alloc(logic cmd, id_t id);
    alloc_word_t w;
    int unsigned lim;
    lim = eff_size();
    w.issued = '0;
    if (cmd == CMD_REGISTER) begin
      if (id < lim) used_bits[id] = 1'b1;
      if (ptr_next == id && ptr_next != ALL_ONES) ptr_next++;
    end else begin
      w.issued = ptr_next;
      if (ptr_next != ALL_ONES) begin
        ptr_next++;
        while (ptr_next < lim && used_bits[ptr_next]) ptr_next++;
      end
    end
    if (ptr_next == ALL_ONES) ovf_seen = 1'b1;
    w.next_free = ptr_next;
    w.ovf = ovf_seen;
    return w;
  endfunction

  task automatic report_mismatch(string what, id_t got, id_t exp_val);
    $display("%0t ns: %s mismatch: got %h, want %h", $time, what, got, exp_val);
    mismatches++;
  endtask

  function automatic void add_word(logic cmd, id_t id);
    cmd_word_t c;
    c.cmd = cmd;
    c.id = id;
    cmd_queue.push_back(c);
  endfunction

  // driver: holds a word until start && !busy, then moves on
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_allocs.push_back(predict_alloc(command, instance_id));
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (cmd_queue.size() > 0) begin
          drv_word = cmd_queue.pop_front();
          start <= 1'b1;
          command <= drv_word.cmd;
          instance_id <= drv_word.id;
          if (idle_en && $urandom_range(0, 4) == 0) gap_left = $urandom_range(1, 9);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_allocs.size() == 0) begin
        report_mismatch("unexpected word, issued_id", issued_id, '0);
      end else begin
        want = expected_allocs.pop_front();
        if (issued_id !== want.issued) report_mismatch("issued_id", issued_id, want.issued);
        if (next_free !== want.next_free)
          report_mismatch("next_free", next_free, want.next_free);
        if (overflow !== want.ovf) report_mismatch("overflow", id_t'(overflow), id_t'(want.ovf));
      end
    end
  end

  // watchdog on cycles with no word moving either way
  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_TOUT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_drained();
    while (cmd_queue.size() != 0 || start || expected_allocs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy || done || expected_allocs.size() != 0) @(posedge clk);
  endtask

  task automatic write_map_size(cfg_t v);
    wait_drained();
    map_size_we <= 1'b1;
    map_size <= v;
    @(posedge clk);
    map_size_we <= 1'b0;
    cfg_size = v;
  endtask

  // mostly words around the pointer so scans cross used runs; some noise
  task automatic queue_random(int n);
    int unsigned r;
    int unsigned lim;
    for (int i = 0; i < n; i++) begin
      while (cmd_queue.size() >= 4) @(posedge clk);
      r = $urandom_range(0, 99);
      lim = eff_size();
      if (r < 30) add_word(CMD_GENERATE, id_t'($urandom));
      else if (r < 45) add_word(CMD_REGISTER, ptr_next);
      else if (r < 80) add_word(CMD_REGISTER, ptr_next + $urandom_range(1, 48));
      else if (r < 88) add_word(CMD_REGISTER, id_t'($urandom_range(0, lim)));
      else if (r < 94) add_word(CMD_REGISTER, id_t'($urandom));
      else add_word(CMD_REGISTER, ALL_ONES - $urandom_range(0, 3));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // clearing pass keeps busy high
    while (busy) @(posedge clk);

    write_map_size(CFG_RESET);
    idle_en = 1'b1;
    add_word(CMD_REGISTER, 32'd0);
    add_word(CMD_REGISTER, ALL_ONES);
    add_word(CMD_REGISTER, ALL_ONES - 1);
    add_word(CMD_REGISTER, 32'd1);          // equals pointer: bump
    add_word(CMD_GENERATE, 32'hFFFF_FFFF);  // id ignored
    add_word(CMD_REGISTER, 32'd4);
    add_word(CMD_REGISTER, 32'd5);
    add_word(CMD_REGISTER, 32'd6);
    add_word(CMD_GENERATE, 32'd0);          // scan over 4..6
    add_word(CMD_REGISTER, 32'd1023);       // last tracked id
    add_word(CMD_REGISTER, 32'd1024);       // at size: map untouched
    add_word(CMD_REGISTER, 32'd7);
    add_word(CMD_REGISTER, 32'hA5A5_A5A5);
    add_word(CMD_REGISTER, 32'h5A5A_5A5A);
    add_word(CMD_GENERATE, 32'h5A5A_5A5A);
    add_word(CMD_GENERATE, 32'd0);
    queue_random(280);

    // oversized value acts as full capacity
    write_map_size(cfg_t'(11'h7FF));
    idle_en = ($urandom_range(0, 3) != 0);
    queue_random(300);
    write_map_size(cfg_t'(0));
    idle_en = 1'b1;
    queue_random(200);
    write_map_size(cfg_t'(1));
    idle_en = ($urandom_range(0, 3) != 0);
    queue_random(200);
    write_map_size(cfg_t'($urandom_range(2, 1023)));
    idle_en = 1'b1;
    queue_random(300);
    write_map_size(CFG_RESET);
    idle_en = ($urandom_range(0, 3) != 0);
    queue_random(300);
    write_map_size(cfg_t'($urandom_range(1, 1024)));
    idle_en = 1'b0;
    queue_random(400);

    wait_drained();
    repeat (40) @(posedge clk);
    while (expected_allocs.size() != 0) begin
      want = expected_allocs.pop_front();
      report_mismatch("missing word, next_free", '0, want.next_free);
    end
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
